@@ hw/rtl/tsi_pkg.sv @@
// Shared widths, register indexes and command codes for the timeline segment interpolator.
package tsi_pkg;

  localparam int TIME_W            = 31;
  localparam int SLOT_W            = 6;
  localparam int CNT_W             = 7;
  localparam int APB_DATA_W        = 32;
  localparam int APB_ADDR_W        = 4;
  localparam int DEF_MAX_EVENTS    = 64;
  localparam int DEF_FRACTION_BITS = 16;

  localparam logic [1:0] REG_DURATION  = 2'd0;
  localparam logic [1:0] REG_DIRECTION = 2'd1;
  localparam logic [1:0] REG_COUNT     = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

@@ hw/rtl/tsi_div.sv @@
// Restoring divider that forms the fixed-point fraction of a smaller numerator over a denominator.
module tsi_div
  import tsi_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [TIME_W-1:0]        num_i,
  input  logic [TIME_W-1:0]        den_i,
  output logic                     done_o,
  output logic [FRACTION_BITS-1:0] quot_o
);

  localparam int CW = $clog2(FRACTION_BITS + 1);

  logic [TIME_W-1:0]        rem_q, rem_d;
  logic [TIME_W-1:0]        den_q, den_d;
  logic [FRACTION_BITS-1:0] quot_q, quot_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     run_q, run_d;
  logic                     done_q, done_d;
  logic [TIME_W:0]          shifted;
  logic [TIME_W:0]          diff;

  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = num_i;
      den_d = den_i;
      cnt_d = CW'(FRACTION_BITS);
      run_d = 1'b1;
    end else if (run_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d  = diff[TIME_W-1:0];
        quot_d = {quot_q[FRACTION_BITS-2:0], 1'b1};
      end else begin
        rem_d  = shifted[TIME_W-1:0];
        quot_d = {quot_q[FRACTION_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ hw/rtl/timeline_segment_interp_top.sv @@
// Top level of the timeline segment interpolator: event table memories, walk sequencer and APB registers.
//
//   Channel   Signals                                   Transfer
//   command   start, busy, command_i .. query_time_i    start high while busy is low
//   result    done_o, fraction_o                        one cycle, strobed by done_o
//   config    psel, penable, pwrite, paddr, pwdata      APB access phase, pready high
//
// A load writes the slot's table entry if the slot is below MAX_EVENTS and keeps busy low.
// A query with a zero duration, or with a time equal to it, skips the walk; otherwise the
// sequencer walks the loaded entries, if any (up to MAX_EVENTS, one per cycle), checks the
// span and runs the divider unless it gives 0 or 1.0 outright; the strobe follows the last step.
// Reset zeroes duration and count, sets fwd_q, idles the sequencer; tables hold nothing until loaded.
// The receiver cannot stall, so no result is ever held back.
module timeline_segment_interp_top
  import tsi_pkg::*;
#(
  parameter int MAX_EVENTS    = DEF_MAX_EVENTS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    command_i,
  input  logic [SLOT_W-1:0]       event_slot_i,
  input  logic [TIME_W-1:0]       event_begin_i,
  input  logic [TIME_W-1:0]       event_end_i,
  input  logic [TIME_W-1:0]       query_time_i,
  output logic                    done_o,
  output logic [FRACTION_BITS:0]  fraction_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready
);

  localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CW = $clog2(MAX_EVENTS + 1);
  localparam logic [CW-1:0] N_MAX = CW'(MAX_EVENTS);
  localparam logic [FRACTION_BITS:0] ONE_FIX = {1'b1, {FRACTION_BITS{1'b0}}};

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_PREP = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [TIME_W-1:0] dur_q;
  logic              fwd_q;
  logic [CNT_W-1:0]  evcnt_q;
  logic              cfg_wr;

  logic [TIME_W-1:0] start_mem  [MAX_EVENTS];
  logic [TIME_W-1:0] finish_mem [MAX_EVENTS];
  logic [TIME_W-1:0] rd_start_q, rd_finish_q;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;

  logic [1:0]               state_q, state_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            idx_next;
  logic [CW-1:0]            n_cnt;
  logic [TIME_W-1:0]        last_q, last_d;
  logic [TIME_W-1:0]        t_q, t_d;
  logic signed [TIME_W:0]   num_q, num_d;
  logic signed [TIME_W:0]   den_q, den_d;
  logic                     done_q, done_d;
  logic [FRACTION_BITS:0]   frac_q, frac_d;
  logic                     accept;
  logic                     res_ready;
  logic [FRACTION_BITS:0]   res_val;
  logic                     div_start;
  logic                     div_done;
  logic [FRACTION_BITS-1:0] div_quot;

  logic signed [TIME_W:0] ext_t, ext_s, ext_f, ext_last, ext_dur;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q   <= '0;
      fwd_q   <= 1'b1;
      evcnt_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DURATION:  dur_q   <= pwdata[TIME_W-1:0];
        REG_DIRECTION: fwd_q   <= pwdata[0];
        REG_COUNT:     evcnt_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DURATION:  prdata = {{(APB_DATA_W-TIME_W){1'b0}}, dur_q};
      REG_DIRECTION: prdata = {{(APB_DATA_W-1){1'b0}}, fwd_q};
      REG_COUNT:     prdata = {{(APB_DATA_W-CNT_W){1'b0}}, evcnt_q};
      default:       prdata = '0;
    endcase
  end

  assign n_cnt = ({25'd0, evcnt_q} > 32'(MAX_EVENTS)) ? N_MAX : CW'(evcnt_q);

  assign wr_en    = accept && (command_i == CMD_LOAD) &&
                    ({26'd0, event_slot_i} < 32'(MAX_EVENTS));
  assign wr_addr  = AW'(event_slot_i);
  assign idx_next = idx_q + CW'(1);
  assign rd_addr  = (state_q == ST_WALK) ? idx_next[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_mem[wr_addr]  <= event_begin_i;
      finish_mem[wr_addr] <= event_end_i;
    end
    rd_start_q  <= start_mem[rd_addr];
    rd_finish_q <= finish_mem[rd_addr];
  end

  assign ext_t    = $signed({1'b0, t_q});
  assign ext_s    = $signed({1'b0, rd_start_q});
  assign ext_f    = $signed({1'b0, rd_finish_q});
  assign ext_last = $signed({1'b0, last_q});
  assign ext_dur  = $signed({1'b0, dur_q});

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    last_d    = last_q;
    t_d       = t_q;
    num_d     = num_q;
    den_d     = den_q;
    done_d    = 1'b0;
    frac_d    = frac_q;
    div_start = 1'b0;
    res_ready = 1'b0;
    res_val   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (command_i == CMD_QUERY)) begin
          t_d    = query_time_i;
          last_d = '0;
          idx_d  = '0;
          if ((dur_q == '0) || (query_time_i == dur_q)) begin
            res_ready = 1'b1;
            res_val   = ONE_FIX;
          end else if (n_cnt == '0) begin
            num_d   = $signed({1'b0, query_time_i});
            den_d   = $signed({1'b0, dur_q});
            state_d = ST_PREP;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (t_q < rd_start_q) begin
          num_d   = ext_t - ext_last;
          den_d   = ext_s - ext_last;
          state_d = ST_PREP;
        end else if (t_q < rd_finish_q) begin
          num_d   = ext_t - ext_s;
          den_d   = ext_f - ext_s;
          state_d = ST_PREP;
        end else begin
          last_d = rd_finish_q;
          idx_d  = idx_next;
          if (idx_next == n_cnt) begin
            num_d   = ext_t - ext_f;
            den_d   = ext_dur - ext_f;
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        if ((den_q <= 0) || (num_q >= den_q)) begin
          res_ready = 1'b1;
          res_val   = ONE_FIX;
          state_d   = ST_IDLE;
        end else if (num_q <= 0) begin
          res_ready = 1'b1;
          res_val   = '0;
          state_d   = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_ready = 1'b1;
          res_val   = {1'b0, div_quot};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (res_ready) begin
      done_d = 1'b1;
      frac_d = fwd_q ? res_val : (ONE_FIX - res_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    last_q <= last_d;
    t_q    <= t_d;
    num_q  <= num_d;
    den_q  <= den_d;
    frac_q <= frac_d;
  end

  tsi_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q[TIME_W-1:0]),
    .den_i  (den_q[TIME_W-1:0]),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign done_o     = done_q;
  assign fraction_o = frac_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("Result strobe while a transaction is still in progress.");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (fraction_o <= ONE_FIX))
    else $error("Fraction above one.");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == CMD_LOAD)) |=> (!done_o && !busy))
    else $error("A load transaction produced a result or started a walk.");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("Divider finished outside the divide state.");

endmodule
